// File: sv/cmac_pkg.sv
// Shared types, constants and AES round functions for the AES-128 CMAC tag engine.
package cmac_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [127:0] RbConst = 128'h87;
  localparam logic [3:0] LastRound = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } tag_t;

  // Register indexes on the configuration port.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef enum logic [1:0] {
    JOB_CHAIN,
    JOB_FULL,
    JOB_PAD
  } job_kind_t;

  typedef struct packed {
    logic [127:0] block;
    job_kind_t    kind;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef enum logic [1:0] {
    MD_DERIVE,
    MD_CHAIN,
    MD_TAG
  } back_mode_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [0:9] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round; byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                             input logic final_rnd);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        t[4*c+row] = SBOX[s[4*((c+row)%4)+row]];
      end
    end
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
    end
    aes_round = r;
  endfunction

  // Next AES-128 round key from the current one.
  function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_expand = {w0, w1, w2, w3};
  endfunction

  // Doubling in GF(2^128) for subkey derivation.
  function automatic logic [127:0] gf_dbl(input logic [127:0] v);
    gf_dbl = {v[126:0], 1'b0} ^ (v[127] ? RbConst : 128'd0);
  endfunction

endpackage

// File: sv/cmac_front.sv
// Front end: collects message bytes into blocks and issues block jobs.
module cmac_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  cmac_pkg::msg_t    msg,
  input  logic              q_full,
  output logic              q_push,
  output cmac_pkg::job_t    q_job
);

  logic [4:0]   held;
  logic [4:0]   held_next;
  logic [127:0] blk;
  logic [127:0] blk_next;
  logic         pend;
  logic         pend_next;
  logic         acc;
  logic [3:0]   idx;

  // Pads the held bytes with the marker byte and zeros.
  function automatic logic [127:0] pad_block(input logic [127:0] b, input logic [4:0] n);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n) begin
        r[127-8*i -: 8] = b[127-8*i -: 8];
      end else if (5'(i) == n) begin
        r[127-8*i -: 8] = cmac_pkg::PadByte;
      end else begin
        r[127-8*i -: 8] = 8'h00;
      end
    end
    pad_block = r;
  endfunction

  assign msg_stall = pend || q_full;
  assign acc = msg_valid && !msg_stall;

  always_comb begin
    held_next = held;
    blk_next = blk;
    pend_next = pend;
    q_push = 1'b0;
    q_job.block = blk;
    q_job.kind = cmac_pkg::JOB_CHAIN;
    idx = held[3:0];
    if (pend) begin
      if (!q_full) begin
        q_push = 1'b1;
        q_job.block = pad_block(blk, 5'd1);
        q_job.kind = cmac_pkg::JOB_PAD;
        pend_next = 1'b0;
        held_next = 5'd0;
      end
    end else if (acc) begin
      if (msg.has_byte) begin
        if (held == 5'(cmac_pkg::BlockBytes)) begin
          // A full block followed by more bytes is chained now.
          q_push = 1'b1;
          q_job.block = blk;
          q_job.kind = cmac_pkg::JOB_CHAIN;
          idx = 4'd0;
        end
        for (int i = 0; i < 16; i++) begin
          if (4'(i) == idx) begin
            blk_next[127-8*i -: 8] = msg.data_byte;
          end
        end
        held_next = {1'b0, idx} + 5'd1;
      end
      if (msg.last) begin
        if (q_push) begin
          // The final block is held pending and goes out once the queue is not full.
          pend_next = 1'b1;
        end else begin
          q_push = 1'b1;
          if (held_next == 5'(cmac_pkg::BlockBytes)) begin
            q_job.block = blk_next;
            q_job.kind = cmac_pkg::JOB_FULL;
          end else begin
            q_job.block = pad_block(blk_next, held_next);
            q_job.kind = cmac_pkg::JOB_PAD;
          end
          held_next = 5'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 5'd0;
      pend <= 1'b0;
    end else begin
      held <= held_next;
      pend <= pend_next;
    end
    blk <= blk_next;
  end

endmodule

// File: sv/cmac_queue.sv
// Two-entry job queue between the front end and the cipher back end.
module cmac_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cmac_pkg::job_t push_job,
  input  logic           pop,
  output cmac_pkg::job_t head,
  output logic           full,
  output logic           nonempty
);

  cmac_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// File: sv/cmac_back.sv
// Back end: round-iterative AES-128, CBC chaining, subkey derivation and tag register.
module cmac_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [127:0]   key,
  input  logic           key_write,
  input  logic           q_nonempty,
  input  cmac_pkg::job_t q_head,
  output logic           q_pop,
  output logic           tag_valid,
  input  logic           tag_stall,
  output cmac_pkg::tag_t tag
);

  cmac_pkg::back_state_t state;
  cmac_pkg::back_state_t state_next;
  cmac_pkg::back_mode_t  mode;
  cmac_pkg::back_mode_t  mode_next;
  logic [3:0]   rnd;
  logic [3:0]   rnd_next;
  logic [127:0] st;
  logic [127:0] st_next;
  logic [127:0] rk;
  logic [127:0] rk_next;
  logic [127:0] chain;
  logic [127:0] chain_next;
  logic [127:0] k1;
  logic [127:0] k1_next;
  logic [127:0] k2;
  logic [127:0] k2_next;
  logic         ready;
  logic         ready_next;
  logic         tag_valid_next;
  cmac_pkg::tag_t tag_next;
  logic [127:0] rk_new;
  logic [127:0] st_new;
  logic [127:0] k1_new;

  assign rk_new = cmac_pkg::key_expand(rk, cmac_pkg::RCON[rnd]);
  assign st_new = cmac_pkg::aes_round(st, rk_new, rnd == cmac_pkg::LastRound);
  assign k1_new = cmac_pkg::gf_dbl(st_new);

  always_comb begin
    state_next = state;
    mode_next = mode;
    rnd_next = rnd;
    st_next = st;
    rk_next = rk;
    chain_next = chain;
    k1_next = k1;
    k2_next = k2;
    ready_next = ready;
    tag_next = tag;
    tag_valid_next = tag_valid && tag_stall;
    q_pop = 1'b0;
    unique case (state)
      cmac_pkg::BK_IDLE: begin
        if (q_nonempty) begin
          case (q_head.kind)
            cmac_pkg::JOB_CHAIN: begin
              st_next = q_head.block ^ chain ^ key;
              rk_next = key;
              rnd_next = 4'd0;
              mode_next = cmac_pkg::MD_CHAIN;
              q_pop = 1'b1;
              state_next = cmac_pkg::BK_RUN;
            end
            default: begin
              if (!tag_valid) begin
                rk_next = key;
                rnd_next = 4'd0;
                state_next = cmac_pkg::BK_RUN;
                if (!ready) begin
                  // Encrypt the zero block first; the job stays queued.
                  st_next = key;
                  mode_next = cmac_pkg::MD_DERIVE;
                end else begin
                  st_next = q_head.block ^ chain ^ key ^
                            ((q_head.kind == cmac_pkg::JOB_FULL) ? k1 : k2);
                  mode_next = cmac_pkg::MD_TAG;
                  q_pop = 1'b1;
                end
              end
            end
          endcase
        end
      end
      cmac_pkg::BK_RUN: begin
        rk_next = rk_new;
        st_next = st_new;
        rnd_next = rnd + 4'd1;
        if (rnd == cmac_pkg::LastRound) begin
          state_next = cmac_pkg::BK_IDLE;
          unique case (mode)
            cmac_pkg::MD_DERIVE: begin
              k1_next = k1_new;
              k2_next = cmac_pkg::gf_dbl(k1_new);
              ready_next = 1'b1;
            end
            cmac_pkg::MD_CHAIN: begin
              chain_next = st_new;
            end
            default: begin
              tag_next.tag_high = st_new[127:64];
              tag_next.tag_low = st_new[63:0];
              tag_valid_next = 1'b1;
              chain_next = 128'd0;
            end
          endcase
        end
      end
      default: begin
        state_next = cmac_pkg::BK_IDLE;
      end
    endcase
    if (key_write) begin
      ready_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmac_pkg::BK_IDLE;
      mode <= cmac_pkg::MD_CHAIN;
      rnd <= 4'd0;
      chain <= 128'd0;
      k1 <= 128'd0;
      k2 <= 128'd0;
      ready <= 1'b0;
      tag_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      rnd <= rnd_next;
      chain <= chain_next;
      k1 <= k1_next;
      k2 <= k2_next;
      ready <= ready_next;
      tag_valid <= tag_valid_next;
    end
    st <= st_next;
    rk <= rk_next;
    tag <= tag_next;
  end

endmodule

// File: sv/aes_cmac_tag_engine.sv
// tag_valid rises after the edge that takes the last byte, once the back end has encrypted
// the final block; it takes longer when the subkeys must be derived first or blocks are queued.
// Throughput: one message byte per cycle while msg_stall is low; each block is collected
// byte by byte and encrypted on the shared round-iterative AES unit, as is each final block.
// Reset (rst, synchronous) clears the key, subkeys, chaining value and held byte count.
// Top level: configuration registers and the front end, job queue and back end.
module aes_cmac_tag_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           msg_valid,
  output logic           msg_stall,
  input  cmac_pkg::msg_t msg,
  output logic           tag_valid,
  input  logic           tag_stall,
  output cmac_pkg::tag_t tag,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [63:0]    cfg_data
);

  logic [63:0]    key_high;
  logic [63:0]    key_low;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_nonempty;
  cmac_pkg::job_t q_job;
  cmac_pkg::job_t q_head;

  // Key registers. Any write invalidates the subkeys, which the back end derives again
  // before the next tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= 64'd0;
      key_low <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmac_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        cmac_pkg::REG_KEY_LOW:  key_low <= cfg_data;
        default: key_low <= key_low;
      endcase
    end
  end

  // The front end assembles bytes into blocks and decides whether each block is
  // chained, or closes the message with or without padding.
  cmac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // The queue lets the front end keep taking bytes while the cipher is busy.
  cmac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // The back end runs AES on each job and holds the tag until it is taken.
  cmac_back u_back (
    .clk        (clk),
    .rst        (rst),
    .key        ({key_high, key_low}),
    .key_write  (cfg_we),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .tag_valid  (tag_valid),
    .tag_stall  (tag_stall),
    .tag        (tag)
  );

endmodule
